FILE: design/ebt_pkg.sv
// ============================================================================
// ebt_pkg
// Shared types, codes and helpers for the event binding table.
// ============================================================================
`default_nettype none

package ebt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_UNUSED   = 2'd3
    } action_t;

    // event kinds; code 0 marks a free slot, codes 6 and 7 are invalid
    localparam logic [2:0] KIND_FREE   = 3'd0;
    localparam logic [2:0] KIND_RISE   = 3'd1;
    localparam logic [2:0] KIND_FALL   = 3'd2;
    localparam logic [2:0] KIND_CHANGE = 3'd3;
    localparam logic [2:0] KIND_EVERY  = 3'd4;
    localparam logic [2:0] KIND_AFTER  = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REQ_INST_GPIO  = 3'd0,
        REQ_INST_TIMER = 3'd1,
        REQ_REM_GPIO   = 3'd2,
        REQ_REM_TIMER  = 3'd3,
        REQ_NONE       = 3'd4
    } request_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_CLEAR,
        S_CLOSE
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] source;
        logic [15:0] debounce;
        logic [15:0] handler;
        logic [15:0] generation;
        logic [15:0] reg_time;
    } slot_entry_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

    function automatic logic is_gpio(logic [2:0] k);
        return (k == KIND_RISE) || (k == KIND_FALL) || (k == KIND_CHANGE);
    endfunction

    function automatic logic is_timer(logic [2:0] k);
        return (k == KIND_EVERY) || (k == KIND_AFTER);
    endfunction

    // GPIO kinds match any live GPIO entry on the pin; timers need kind and period
    function automatic logic slot_matches(slot_entry_t e, logic [2:0] k, logic [15:0] src);
        logic hit;
        if (e.kind == KIND_FREE || e.source != src)
            hit = 1'b0;
        else if (is_gpio(k))
            hit = is_gpio(e.kind);
        else
            hit = (e.kind == k);
        return hit;
    endfunction

    function automatic logic [3:0] slot_to_out(slot_idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[3:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/ebt_cell.sv
// ============================================================================
// ebt_cell
// One table entry in the rotating ring: loads from its neighbor or a direct write.
// ============================================================================
`default_nettype none

module ebt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ebt_pkg::cell_ctrl_t ctrl,
    input  wire ebt_pkg::slot_entry_t shift_in,
    input  wire ebt_pkg::slot_entry_t wr_data,
    output      ebt_pkg::slot_entry_t entry
);
    import ebt_pkg::*;

    slot_entry_t entry_reg;
    slot_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr)
            entry_next = wr_data;
        else if (ctrl.shift)
            entry_next = shift_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: design/event_binding_table.sv
// ============================================================================
// event_binding_table
// Table of GPIO and timer event bindings kept in a rotating ring of cells.
// ============================================================================
// Register / cancel / bad word: one ring turn to scan, then the entry is written
//   and the result word registered in the response state, which waits on an output stall.
// Clear: one remove word per live entry during the ring turn, closing word
//   after the turn, plus any output stall.
// One word in flight: a new word is taken only once the last result word is registered.
// Reset (rst_n low, async) zeroes every entry and generation; no clearing pass.
`default_nettype none

module event_binding_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [1:0] action, [4:2] event_kind, [20:5] source_id, [36:21] debounce_time,
    // [52:37] handler_id, [68:53] now_time, [71:69] zero
    input  wire logic [71:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [4:2] request, [8:5] slot_index, [24:9] generation_out,
    // [40:25] source_out, [47:41] zero
    output      logic [47:0] m_tdata,
    output      logic        m_tlast    // last_result
);
    import ebt_pkg::*;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    // ---------------------------------------------------------------- state
    state_t      state_reg, state_next;
    slot_idx_t   cnt_reg, cnt_next;

    // captured input word
    action_t     act_reg, act_next;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] deb_reg, deb_next;
    logic [15:0] hnd_reg, hnd_next;
    logic [15:0] now_reg, now_next;

    // scan results: first matching live entry and first free entry
    logic        hit_reg, hit_next;
    slot_idx_t   hit_idx_reg, hit_idx_next;
    logic [2:0]  hit_kind_reg, hit_kind_next;
    logic [15:0] hit_gen_reg, hit_gen_next;
    logic        free_reg, free_next;
    slot_idx_t   free_idx_reg, free_idx_next;
    logic [15:0] free_gen_reg, free_gen_next;

    // output register
    logic        ov_reg, ov_next;
    status_t     ostat_reg, ostat_next;
    request_t    oreq_reg, oreq_next;
    logic [3:0]  oslot_reg, oslot_next;
    logic [15:0] ogen_reg, ogen_next;
    logic [15:0] osrc_reg, osrc_next;
    logic        olast_reg, olast_next;

    // ---------------------------------------------------------------- ring
    slot_entry_t cell_q [TABLE_SLOTS];
    cell_ctrl_t  cell_ctrl [TABLE_SLOTS];
    slot_entry_t tail_in;
    slot_entry_t wr_data;
    slot_idx_t   wr_idx;
    logic        wr_en;
    logic        shift_all;
    slot_entry_t head;

    logic        s_acc;
    logic        out_free;
    logic        head_live;
    logic        bad_word;
    logic [15:0] new_gen;

    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !ov_reg || m_tready;
    assign head      = cell_q[0];
    assign head_live = (head.kind != KIND_FREE);
    assign bad_word  = (act_reg == ACT_UNUSED) || !(is_gpio(kind_reg) || is_timer(kind_reg));

    // Slot k sits at the head after k shifts; a full turn restores the order,
    // so direct writes address cells by slot number once the scan is done.
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        slot_entry_t nb_in;
        if (i == TABLE_SLOTS - 1)
        begin : g_tail
            assign nb_in = tail_in;
        end
        else
        begin : g_mid
            assign nb_in = cell_q[i+1];
        end

        assign cell_ctrl[i].shift = shift_all;
        assign cell_ctrl[i].wr    = wr_en && (wr_idx == SLOT_W'(i));

        ebt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[i]),
            .shift_in (nb_in),
            .wr_data  (wr_data),
            .entry    (cell_q[i])
        );
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (action_t'(s_tdata[1:0]) == ACT_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (cnt_reg == LAST_SLOT && (!head_live || out_free))
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs / datapath
    always_comb
    begin
        cnt_next      = cnt_reg;
        act_next      = act_reg;
        kind_next     = kind_reg;
        src_next      = src_reg;
        deb_next      = deb_reg;
        hnd_next      = hnd_reg;
        now_next      = now_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_kind_next = hit_kind_reg;
        hit_gen_next  = hit_gen_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        free_gen_next = free_gen_reg;

        ov_next    = ov_reg && !m_tready;
        ostat_next = ostat_reg;
        oreq_next  = oreq_reg;
        oslot_next = oslot_reg;
        ogen_next  = ogen_reg;
        osrc_next  = osrc_reg;
        olast_next = olast_reg;

        shift_all = 1'b0;
        tail_in   = head;
        wr_en     = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_data   = '0;
        new_gen   = 16'(hit_gen_reg + 16'd1);
        s_tready  = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    act_next  = action_t'(s_tdata[1:0]);
                    kind_next = s_tdata[4:2];
                    src_next  = s_tdata[20:5];
                    deb_next  = s_tdata[36:21];
                    hnd_next  = s_tdata[52:37];
                    now_next  = s_tdata[68:53];
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                shift_all = 1'b1;
                cnt_next  = SLOT_W'(cnt_reg + 1'b1);
                if (!hit_reg && slot_matches(head, kind_reg, src_reg))
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = cnt_reg;
                    hit_kind_next = head.kind;
                    hit_gen_next  = head.generation;
                end
                if (!free_reg && !head_live)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cnt_reg;
                    free_gen_next = head.generation;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b1;
                    ostat_next = ST_OK;
                    oreq_next  = REQ_NONE;
                    oslot_next = '0;
                    ogen_next  = '0;
                    osrc_next  = '0;
                    if (bad_word)
                        ostat_next = ST_INVALID;
                    else if (act_reg == ACT_REGISTER)
                    begin
                        if (hit_reg || free_reg)
                        begin
                            // a live match wins over the first free slot
                            wr_idx  = hit_reg ? hit_idx_reg : free_idx_reg;
                            new_gen = 16'((hit_reg ? hit_gen_reg : free_gen_reg) + 16'd1);
                            wr_en   = 1'b1;
                            wr_data.kind       = kind_reg;
                            wr_data.source     = src_reg;
                            wr_data.debounce   = deb_reg;
                            wr_data.handler    = hnd_reg;
                            wr_data.generation = new_gen;
                            wr_data.reg_time   = now_reg;
                            oreq_next  = is_gpio(kind_reg) ? REQ_INST_GPIO : REQ_INST_TIMER;
                            oslot_next = slot_to_out(wr_idx);
                            ogen_next  = new_gen;
                            osrc_next  = src_reg;
                        end
                        else
                            ostat_next = ST_FULL;
                    end
                    else if (hit_reg)
                    begin
                        // cancel: entry wiped, generation kept and bumped
                        wr_en   = 1'b1;
                        wr_data.generation = new_gen;
                        oreq_next  = is_gpio(hit_kind_reg) ? REQ_REM_GPIO : REQ_REM_TIMER;
                        oslot_next = slot_to_out(hit_idx_reg);
                        ogen_next  = new_gen;
                        osrc_next  = src_reg;
                    end
                    else
                        ostat_next = ST_NOT_FOUND;
                end
            end
            S_CLEAR:
            begin
                tail_in = '0;
                if (!head_live || out_free)
                begin
                    shift_all = 1'b1;
                    cnt_next  = SLOT_W'(cnt_reg + 1'b1);
                end
                if (head_live && out_free)
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b0;
                    ostat_next = ST_OK;
                    oreq_next  = is_gpio(head.kind) ? REQ_REM_GPIO : REQ_REM_TIMER;
                    oslot_next = slot_to_out(cnt_reg);
                    ogen_next  = head.generation;
                    osrc_next  = head.source;
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b1;
                    ostat_next = ST_OK;
                    oreq_next  = REQ_NONE;
                    oslot_next = '0;
                    ogen_next  = '0;
                    osrc_next  = '0;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        kind_reg     <= kind_next;
        src_reg      <= src_next;
        deb_reg      <= deb_next;
        hnd_reg      <= hnd_next;
        now_reg      <= now_next;
        hit_idx_reg  <= hit_idx_next;
        hit_kind_reg <= hit_kind_next;
        hit_gen_reg  <= hit_gen_next;
        free_idx_reg <= free_idx_next;
        free_gen_reg <= free_gen_next;
        ostat_reg    <= ostat_next;
        oreq_reg     <= oreq_next;
        oslot_reg    <= oslot_next;
        ogen_reg     <= ogen_next;
        osrc_reg     <= osrc_next;
        olast_reg    <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, osrc_reg, ogen_reg, oslot_reg, oreq_reg, ostat_reg};
    assign m_tlast  = olast_reg;

    // ---------------------------------------------------------------- checks
    // scan walks the ring one slot per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cnt_reg != LAST_SLOT)
            |=> (cnt_reg == SLOT_W'($past(cnt_reg) + 1'b1)))
        else $error("scan counter skipped");

    // clear ring holds while a remove word waits for the output register
    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && head_live && !out_free) |=> $stable(cnt_reg))
        else $error("clear advanced past a live entry");

    // non-final words are removes from the clear sweep
    a_mid_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !olast_reg) |-> (oreq_reg == REQ_REM_GPIO || oreq_reg == REQ_REM_TIMER))
        else $error("non-final word is not a remove");

    // an error status never carries a platform request
    a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ostat_reg != ST_OK) |-> (oreq_reg == REQ_NONE))
        else $error("error word carries a request");

    // an accepted word always leaves idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> (state_reg != S_IDLE))
        else $error("accepted word not processed");

endmodule

`default_nettype wire

FILE: test/tb_event_binding_table.sv
// ============================================================================
// tb_event_binding_table
// Self-checking regression for the event binding table.
// ============================================================================
// A scoreboard class keeps its own copy of the sixteen bindings. It works out
// the reply words for every accepted command word and checks each reply word
// in order.
// Stimulus starts with a directed pass over the corner cases. Random
// scenarios follow:
//   - single register and cancel words on a narrow pin/period pool
//   - register-then-cancel pairs
//   - fill bursts that run the table into the full error
//   - clears
//   - random noise
// The sender idles in bursts. The receiver stalls in modes that change over
// the run.
// ============================================================================

module tb_event_binding_table;

    timeunit 1ns;
    timeprecision 1ps;

    import ebt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 400;
    localparam int TAIL_CYCLES  = 50;

    // kind codes with no meaning
    localparam logic [2:0] KIND_BAD_LO = 3'd6;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    // one reply word as the block should emit it
    typedef struct {
        status_t     status;
        request_t    request;
        logic [3:0]  slot;
        logic [15:0] generation;
        logic [15:0] source;
        logic        is_last;
    } reply_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the binding table plus the reply words owed
    // ------------------------------------------------------------------------
    class binding_scoreboard;
        logic [2:0]  kind_tbl     [TABLE_SLOTS];
        logic [15:0] source_tbl   [TABLE_SLOTS];
        logic [15:0] debounce_tbl [TABLE_SLOTS];
        logic [15:0] handler_tbl  [TABLE_SLOTS];
        logic [15:0] gen_tbl      [TABLE_SLOTS];
        logic [15:0] stamp_tbl    [TABLE_SLOTS];
        reply_t      expected_replies[$];
        int          errors;

        function new();
            errors = 0;
            zero_table();
        endfunction

        function void wipe_slot(int s);
            kind_tbl[s]     = KIND_FREE;
            source_tbl[s]   = '0;
            debounce_tbl[s] = '0;
            handler_tbl[s]  = '0;
            stamp_tbl[s]    = '0;
        endfunction

        // reset and clear both drop generations as well
        function void zero_table();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                wipe_slot(i);
                gen_tbl[i] = '0;
            end
        endfunction

        function bit gpio_kind(logic [2:0] k);
            return k inside {KIND_RISE, KIND_FALL, KIND_CHANGE};
        endfunction

        function bit timer_kind(logic [2:0] k);
            return k inside {KIND_EVERY, KIND_AFTER};
        endfunction

        // GPIO kinds share a pin regardless of edge; timers need exact kind
        function bit binding_hit(int s, logic [2:0] k, logic [15:0] src);
            if (kind_tbl[s] == KIND_FREE || source_tbl[s] != src)
                return 1'b0;
            if (gpio_kind(k))
                return gpio_kind(kind_tbl[s]);
            return kind_tbl[s] == k;
        endfunction

        function void owe_reply(status_t st, request_t rq, int slot,
                                logic [15:0] gen, logic [15:0] src, logic is_last);
            reply_t r;
            r.status     = st;
            r.request    = rq;
            r.slot       = slot[3:0];
            r.generation = gen;
            r.source     = src;
            r.is_last    = is_last;
            expected_replies.push_back(r);
        endfunction

        // apply one accepted command word to the shadow table
        function void accept_command(logic [71:0] w);
            action_t     act;
            logic [2:0]  k;
            logic [15:0] src;
            logic [15:0] deb;
            logic [15:0] hnd;
            logic [15:0] stamp;
            request_t    rq;
            int          hit;

            act   = action_t'(w[1:0]);
            k     = w[4:2];
            src   = w[20:5];
            deb   = w[36:21];
            hnd   = w[52:37];
            stamp = w[68:53];

            if (act == ACT_CLEAR)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (kind_tbl[i] != KIND_FREE)
                    begin
                        rq = gpio_kind(kind_tbl[i]) ? REQ_REM_GPIO : REQ_REM_TIMER;
                        owe_reply(ST_OK, rq, i, gen_tbl[i], source_tbl[i], 1'b0);
                    end
                end
                zero_table();
                owe_reply(ST_OK, REQ_NONE, 0, '0, '0, 1'b1);
                return;
            end

            if (act == ACT_UNUSED || !(gpio_kind(k) || timer_kind(k)))
            begin
                owe_reply(ST_INVALID, REQ_NONE, 0, '0, '0, 1'b1);
                return;
            end

            hit = -1;
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (hit < 0 && binding_hit(i, k, src))
                    hit = i;

            if (act == ACT_REGISTER)
            begin
                // no live match: take the first free slot
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (hit < 0 && kind_tbl[i] == KIND_FREE)
                        hit = i;
                if (hit < 0)
                begin
                    owe_reply(ST_FULL, REQ_NONE, 0, '0, '0, 1'b1);
                    return;
                end
                kind_tbl[hit]     = k;
                source_tbl[hit]   = src;
                debounce_tbl[hit] = deb;
                handler_tbl[hit]  = hnd;
                stamp_tbl[hit]    = stamp;
                gen_tbl[hit]      = gen_tbl[hit] + 16'd1;
                rq = gpio_kind(k) ? REQ_INST_GPIO : REQ_INST_TIMER;
                owe_reply(ST_OK, rq, hit, gen_tbl[hit], src, 1'b1);
                return;
            end

            // cancel
            if (hit < 0)
            begin
                owe_reply(ST_NOT_FOUND, REQ_NONE, 0, '0, '0, 1'b1);
                return;
            end
            rq  = gpio_kind(kind_tbl[hit]) ? REQ_REM_GPIO : REQ_REM_TIMER;
            src = source_tbl[hit];
            wipe_slot(hit);
            gen_tbl[hit] = gen_tbl[hit] + 16'd1;
            owe_reply(ST_OK, rq, hit, gen_tbl[hit], src, 1'b1);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // check one accepted reply word against the oldest owed reply
        function void check_reply(logic [47:0] d, logic is_last);
            reply_t e;
            if (expected_replies.size() == 0)
            begin
                $error("reply word %h arrived with nothing owed", d);
                errors++;
                return;
            end
            e = expected_replies.pop_front();
            compare_field("status",         16'(e.status),  16'(d[1:0]));
            compare_field("request",        16'(e.request), 16'(d[4:2]));
            compare_field("slot_index",     16'(e.slot),    16'(d[8:5]));
            compare_field("generation_out", e.generation,   d[24:9]);
            compare_field("source_out",     e.source,       d[40:25]);
            compare_field("last_result",    16'(e.is_last), 16'(is_last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // action, kind, source, debounce, handler, now
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status, request, slot, generation, source
    logic        m_tlast;         // last_result

    event_binding_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    binding_scoreboard board = new();

    int          cycle_count    = 0;
    int          words_accepted = 0;
    int          burst_left     = 0;
    logic [2:0]  live_kinds[5]  = '{KIND_RISE, KIND_FALL, KIND_CHANGE, KIND_EVERY, KIND_AFTER};

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("event_binding_table regression: fail");
            $finish;
        end
    end

    // reply monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_reply(m_tdata, m_tlast);
    end

    // receiver: stall mode changes at random over the run
    //   0 never stalls, 1 coin flip, 2 ready one cycle in four, 3 stalls one in four
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 120);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_phase % 4 == 0);
            default: m_tready <= (stall_phase % 4 != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender: drive one command word, hold it until taken, then maybe idle
    // ------------------------------------------------------------------------
    task automatic send_cmd(action_t act, logic [2:0] k, logic [15:0] src,
                            logic [15:0] deb, logic [15:0] hnd, logic [15:0] stamp);
        logic [71:0] w;
        int          gap;
        w = {3'b000, stamp, hnd, deb, src, k, act};
        @(negedge clk);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        board.accept_command(w);
        words_accepted++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // end of burst: idle a while, landing on any phase of the scan
            gap        = $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_source();
        // mostly a small pool so that pins and periods collide
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 5));
    endfunction

    function automatic logic [2:0] pick_kind();
        if ($urandom_range(0, 9) == 0)
            return 3'($urandom_range(0, 7));
        return live_kinds[$urandom_range(0, 4)];
    endfunction

    task automatic random_register();
        send_cmd(ACT_REGISTER, pick_kind(), pick_source(),
                 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // fill burst: enough distinct bindings to hit the full error
    task automatic fill_table();
        int n;
        n = $urandom_range(TABLE_SLOTS + 1, TABLE_SLOTS + 4);
        repeat (n)
            send_cmd(ACT_REGISTER, live_kinds[$urandom_range(0, 4)],
                     16'($urandom_range(0, 65535)),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          pick;
        int          start_count;
        logic [2:0]  k;
        logic [15:0] src;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        send_cmd(ACT_REGISTER, KIND_RISE,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // other edge on same pin reuses the entry
        send_cmd(ACT_REGISTER, KIND_FALL,   16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_REGISTER, KIND_CHANGE, 16'hFFFF, 16'h1234, 16'hABCD, 16'h0042);
        // timers ignore a GPIO on the same number, and each other's kind
        send_cmd(ACT_REGISTER, KIND_EVERY,  16'hFFFF, 16'h0001, 16'h0002, 16'h0003);
        send_cmd(ACT_REGISTER, KIND_AFTER,  16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555);
        send_cmd(ACT_REGISTER, KIND_EVERY,  16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF);
        // cancel found, with a different GPIO edge than stored
        send_cmd(ACT_CANCEL,   KIND_RISE,   16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(ACT_CANCEL,   KIND_AFTER,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        // not found: already gone, and a timer against a GPIO pin
        send_cmd(ACT_CANCEL,   KIND_AFTER,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(ACT_CANCEL,   KIND_EVERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // invalid kinds and the unused action
        send_cmd(ACT_REGISTER, KIND_FREE,   16'h0007, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_REGISTER, KIND_BAD_LO, 16'h0007, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(ACT_CANCEL,   KIND_BAD_HI, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(ACT_UNUSED,   KIND_RISE,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // freed slot comes back with its generation kept
        send_cmd(ACT_REGISTER, KIND_RISE,   16'h1234, 16'h0010, 16'h0020, 16'h0030);
        // clear with live entries, then on an empty table
        send_cmd(ACT_CLEAR,    KIND_FREE,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(ACT_CLEAR,    KIND_BAD_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_CANCEL,   KIND_RISE,   16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random part; the first scenario always runs the table full
        start_count = words_accepted;
        fill_table();
        send_cmd(ACT_CLEAR, pick_kind(), pick_source(),
                 16'($urandom), 16'($urandom), 16'($urandom));
        while (words_accepted - start_count < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 33)
                random_register();
            else if (pick < 55)
                send_cmd(ACT_CANCEL, pick_kind(), pick_source(),
                         16'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 63)
                fill_table();
            else if (pick < 70)
                send_cmd(ACT_CLEAR, 3'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 78)
                // noise: every field random
                send_cmd(action_t'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                // register then cancel, the cancel sometimes with another edge
                k   = live_kinds[$urandom_range(0, 4)];
                src = pick_source();
                send_cmd(ACT_REGISTER, k, src,
                         16'($urandom), 16'($urandom), 16'($urandom));
                if (k != KIND_EVERY && k != KIND_AFTER && $urandom_range(0, 1))
                    k = live_kinds[$urandom_range(0, 2)];
                send_cmd(ACT_CANCEL, k, src,
                         16'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain owed replies, then give the block time to send anything stray
        while (board.expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("event_binding_table regression: pass");
        else
            $display("event_binding_table regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/ebt_pkg.sv
design/ebt_cell.sv
design/event_binding_table.sv
test/tb_event_binding_table.sv
